>>> rtl/lcpc_pkg.sv
`timescale 1ns / 1ps
package lcpc_pkg;

  // Widths of the datapath.
  localparam int COUNT_BITS      = 32;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int MANT_FRAC       = 30;
  localparam int MANT_W          = MANT_FRAC + 1;
  localparam int P_W             = $clog2(COUNT_BITS);
  localparam int LOG_W           = P_W + RATIO_FRAC_BITS;
  localparam int RATIO_W         = RATIO_FRAC_BITS + 1;
  localparam int COLOUR_W        = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  // Ratio of exactly 1.0 and the black threshold of one quarter.
  localparam logic [RATIO_W-1:0] RATIO_ONE     = RATIO_W'(1) << RATIO_FRAC_BITS;
  localparam logic [RATIO_W-1:0] RATIO_QUARTER = RATIO_W'(1) << (RATIO_FRAC_BITS - 2);
  localparam logic [COLOUR_W-1:0] FULL_SCALE   = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_RED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_GREEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_BLUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE   = 3'd4;

  // One log2 evaluation in flight: exponent, mantissa and fraction so far.
  typedef struct packed {
    logic [P_W-1:0]             p;
    logic [MANT_W-1:0]          m;
    logic [RATIO_FRAC_BITS-1:0] frac;
  } lane_t;

  typedef struct packed {
    logic  black;
    lane_t cnt;
    lane_t mx;
  } log_stage_t;

  typedef struct packed {
    logic                       black;
    logic                       clamp;
    logic [LOG_W-1:0]           rem;
    logic [LOG_W-1:0]           den;
    logic [RATIO_FRAC_BITS-1:0] quo;
  } div_stage_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic                alpha_mode;
  } colour_cfg_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic [COLOUR_W-1:0] alpha;
  } pixel_t;

  // One squaring step: square the mantissa, truncate, and pull out one fraction bit.
  function automatic lane_t square_step(lane_t l);
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     s;
    lane_t               r;
    r  = l;
    sq = {{MANT_W{1'b0}}, l.m} * {{MANT_W{1'b0}}, l.m};
    s  = sq[MANT_FRAC +: MANT_W+1];
    if (s[MANT_W]) begin
      r.m    = s[MANT_W:1];
      r.frac = {l.frac[RATIO_FRAC_BITS-2:0], 1'b1};
    end else begin
      r.m    = s[MANT_W-1:0];
      r.frac = {l.frac[RATIO_FRAC_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

>>> rtl/lcpc_in_if.sv
`timescale 1ns / 1ps
interface lcpc_in_if;
  import lcpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] hit_count;
  modport source (output valid, output hit_count, input ready);
  modport sink (input valid, input hit_count, output ready);
endinterface

>>> rtl/lcpc_out_if.sv
`timescale 1ns / 1ps
interface lcpc_out_if;
  import lcpc_pkg::*;
  logic                valid;
  logic                ready;
  logic [COLOUR_W-1:0] pixel_red;
  logic [COLOUR_W-1:0] pixel_green;
  logic [COLOUR_W-1:0] pixel_blue;
  logic [COLOUR_W-1:0] pixel_alpha;
  modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                  output pixel_alpha, input ready);
  modport sink (input valid, input pixel_red, input pixel_green, input pixel_blue,
                input pixel_alpha, output ready);
endinterface

>>> rtl/lcpc_cfg_if.sv
`timescale 1ns / 1ps
interface lcpc_cfg_if;
  import lcpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/lcpc_log_cell.sv
`timescale 1ns / 1ps
module lcpc_log_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  lcpc_pkg::log_stage_t d_i,
  output logic                 vld_o,
  output lcpc_pkg::log_stage_t d_o
);
  import lcpc_pkg::*;

  logic       vld_r;
  log_stage_t d_r;
  log_stage_t d_nxt;

  // Both lanes, count and normaliser, take one squaring step.
  always_comb begin
    d_nxt       = d_i;
    d_nxt.cnt   = square_step(d_i.cnt);
    d_nxt.mx    = square_step(d_i.mx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;
endmodule

>>> rtl/lcpc_div_cell.sv
`timescale 1ns / 1ps
module lcpc_div_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  lcpc_pkg::div_stage_t d_i,
  output logic                 vld_o,
  output lcpc_pkg::div_stage_t d_o
);
  import lcpc_pkg::*;

  logic           vld_r;
  div_stage_t     d_r;
  div_stage_t     d_nxt;
  logic [LOG_W:0] rem2;

  // One restoring division step yields one quotient bit.
  always_comb begin
    d_nxt = d_i;
    rem2  = {d_i.rem, 1'b0};
    if (rem2 >= {1'b0, d_i.den}) begin
      d_nxt.rem = LOG_W'(rem2 - {1'b0, d_i.den});
      d_nxt.quo = {d_i.quo[RATIO_FRAC_BITS-2:0], 1'b1};
    end else begin
      d_nxt.rem = rem2[LOG_W-1:0];
      d_nxt.quo = {d_i.quo[RATIO_FRAC_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;
endmodule

>>> rtl/lcpc_scale.sv
`timescale 1ns / 1ps
module lcpc_scale (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  lcpc_pkg::div_stage_t  d_i,
  input  lcpc_pkg::colour_cfg_t cfg,
  output logic                  vld_o,
  output lcpc_pkg::pixel_t      pix_o
);
  import lcpc_pkg::*;

  localparam int PROD_W = COLOUR_W + RATIO_W;

  logic                vld_r;
  pixel_t              pix_r;
  pixel_t              pix_nxt;
  logic [RATIO_W-1:0]  ratio;
  logic                black;
  logic [PROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]   prod_g;
  logic [PROD_W-1:0]   prod_b;
  logic [PROD_W-1:0]   prod_a;

  // Clamp the ratio; give black, or scale the alpha or colour channels.
  always_comb begin
    ratio  = d_i.clamp ? RATIO_ONE : {1'b0, d_i.quo};
    black  = d_i.black || (ratio <= RATIO_QUARTER);
    prod_r = PROD_W'(cfg.red) * PROD_W'(ratio);
    prod_g = PROD_W'(cfg.green) * PROD_W'(ratio);
    prod_b = PROD_W'(cfg.blue) * PROD_W'(ratio);
    prod_a = PROD_W'(FULL_SCALE) * PROD_W'(ratio);
    if (black) begin
      pix_nxt = '{red: '0, green: '0, blue: '0, alpha: FULL_SCALE};
    end else if (cfg.alpha_mode) begin
      pix_nxt = '{red: cfg.red, green: cfg.green, blue: cfg.blue,
                  alpha: prod_a[RATIO_FRAC_BITS +: COLOUR_W]};
    end else begin
      pix_nxt = '{red:   prod_r[RATIO_FRAC_BITS +: COLOUR_W],
                  green: prod_g[RATIO_FRAC_BITS +: COLOUR_W],
                  blue:  prod_b[RATIO_FRAC_BITS +: COLOUR_W],
                  alpha: FULL_SCALE};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  assign vld_o = vld_r;
  assign pix_o = pix_r;
endmodule

>>> rtl/log_count_pixel_colour_map_core.sv
`timescale 1ns / 1ps
// Logarithmic tone mapping of one hit count to one RGBA pixel.
// in_ch carries one hit_count per beat; out_ch returns one pixel per beat, in order.
// cfg_ch writes max_count, the base colour and alpha_mode; it is always ready and
// must only be used while no pixel is in flight.
// Throughput: one beat per cycle unless the receiver stalls. From input beat to output
// beat a hit count passes one normalize stage, a row of 16 squaring cells that each
// produce one log2 fraction bit for both the count and max_count, a row of 16
// restoring division cells that each produce one ratio bit, and one scaling stage
// that holds the output register.
// When the receiver stalls, the whole row of cells holds and in_ch.ready drops
// in the same cycle; no beat is lost or repeated.
// Synchronous reset clears every stage valid and loads max_count 1, white base
// colour and colour-channel mode.
module log_count_pixel_colour_map_core (
  input  logic       clk,
  input  logic       rst_n,
  lcpc_in_if.sink    in_ch,
  lcpc_out_if.source out_ch,
  lcpc_cfg_if.sink   cfg_ch
);
  import lcpc_pkg::*;

  localparam int EXT_W = COUNT_BITS + MANT_FRAC;

  logic [COUNT_BITS-1:0]  max_count_r;
  colour_cfg_t            cfg_r;
  logic                   en;
  logic [P_W-1:0]         cnt_p;
  logic [P_W-1:0]         max_p;
  logic [EXT_W-1:0]       cnt_ext;
  logic [EXT_W-1:0]       max_ext;
  log_stage_t             norm_nxt;
  logic                   log_v [0:RATIO_FRAC_BITS];
  log_stage_t             log_d [0:RATIO_FRAC_BITS];
  logic                   div_v [0:RATIO_FRAC_BITS];
  div_stage_t             div_d [0:RATIO_FRAC_BITS];
  logic [LOG_W-1:0]       log_cnt;
  logic [LOG_W-1:0]       log_max;
  pixel_t                 pix;

  // Configuration writes.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_count_r <= COUNT_BITS'(1);
      cfg_r       <= '{red: FULL_SCALE, green: FULL_SCALE, blue: FULL_SCALE,
                       alpha_mode: 1'b0};
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MAX_COUNT:    max_count_r      <= cfg_ch.data[COUNT_BITS-1:0];
        REG_COLOUR_RED:   cfg_r.red        <= cfg_ch.data[COLOUR_W-1:0];
        REG_COLOUR_GREEN: cfg_r.green      <= cfg_ch.data[COLOUR_W-1:0];
        REG_COLOUR_BLUE:  cfg_r.blue       <= cfg_ch.data[COLOUR_W-1:0];
        REG_ALPHA_MODE:   cfg_r.alpha_mode <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // The whole row advances unless the output beat is held.
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Leading-one search and mantissa normalization for both lanes.
  always_comb begin
    cnt_p = '0;
    max_p = '0;
    for (int i = 0; i < COUNT_BITS; i++) begin
      if (in_ch.hit_count[i]) cnt_p = P_W'(i);
      if (max_count_r[i])     max_p = P_W'(i);
    end
    cnt_ext = {in_ch.hit_count, {MANT_FRAC{1'b0}}} >> cnt_p;
    max_ext = {max_count_r, {MANT_FRAC{1'b0}}} >> max_p;
    norm_nxt.black    = (in_ch.hit_count <= COUNT_BITS'(1)) ||
                        (max_count_r <= COUNT_BITS'(1));
    norm_nxt.cnt.p    = cnt_p;
    norm_nxt.cnt.m    = cnt_ext[MANT_W-1:0];
    norm_nxt.cnt.frac = '0;
    norm_nxt.mx.p     = max_p;
    norm_nxt.mx.m     = max_ext[MANT_W-1:0];
    norm_nxt.mx.frac  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_v[0] <= 1'b0;
    end else if (en) begin
      log_v[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      log_d[0] <= norm_nxt;
    end
  end

  // Row of squaring cells, one fraction bit each.
  for (genvar g = 0; g < RATIO_FRAC_BITS; g++) begin : g_log
    lcpc_log_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (log_v[g]),
      .d_i   (log_d[g]),
      .vld_o (log_v[g+1]),
      .d_o   (log_d[g+1])
    );
  end

  // Set up the division; a count log at or above the normaliser log clamps to 1.0.
  assign log_cnt = {log_d[RATIO_FRAC_BITS].cnt.p, log_d[RATIO_FRAC_BITS].cnt.frac};
  assign log_max = {log_d[RATIO_FRAC_BITS].mx.p, log_d[RATIO_FRAC_BITS].mx.frac};

  always_comb begin
    div_v[0]       = log_v[RATIO_FRAC_BITS];
    div_d[0].black = log_d[RATIO_FRAC_BITS].black;
    div_d[0].clamp = log_cnt >= log_max;
    div_d[0].rem   = (log_cnt >= log_max) ? '0 : log_cnt;
    div_d[0].den   = log_max;
    div_d[0].quo   = '0;
  end

  // Row of division cells, one ratio bit each.
  for (genvar g = 0; g < RATIO_FRAC_BITS; g++) begin : g_div
    lcpc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (div_v[g]),
      .d_i   (div_d[g]),
      .vld_o (div_v[g+1]),
      .d_o   (div_d[g+1])
    );
  end

  // Scaling and output register.
  lcpc_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (div_v[RATIO_FRAC_BITS]),
    .d_i   (div_d[RATIO_FRAC_BITS]),
    .cfg   (cfg_r),
    .vld_o (out_ch.valid),
    .pix_o (pix)
  );

  assign out_ch.pixel_red   = pix.red;
  assign out_ch.pixel_green = pix.green;
  assign out_ch.pixel_blue  = pix.blue;
  assign out_ch.pixel_alpha = pix.alpha;
endmodule

>>> tb/tb_log_count_pixel_colour_map_core.sv
`timescale 1ns / 1ps
module tb_log_count_pixel_colour_map_core;
  import lcpc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lcpc_in_if  in_ch ();
  lcpc_out_if out_ch ();
  lcpc_cfg_if cfg_ch ();

  log_count_pixel_colour_map_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #5 clk = ~clk;

  // Local copy of the configuration, updated on every accepted register write.
  logic [31:0] norm_count = 32'd1;
  logic [7:0]  base_red   = 8'd255;
  logic [7:0]  base_green = 8'd255;
  logic [7:0]  base_blue  = 8'd255;
  logic        scale_alpha = 1'b0;

  logic [31:0] count_q[$];
  pixel_t      pixel_q[$];
  int          errors = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;

  // Directed counts for the colour-mode and alpha-mode checks.
  logic [31:0] colour_counts [14] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd6, 32'd31,
                                      32'd32, 32'd999, 32'd1000, 32'd1001, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'hFFFF_FFFF};
  logic [31:0] alpha_counts [8]   = '{32'd1, 32'd2, 32'd255, 32'd65536, 32'h0100_0000,
                                      32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};

  // Fixed-point log2 as integer.16: leading-one position, then 16 squaring steps.
  function automatic longint unsigned fixed_log2(logic [31:0] x);
    int unsigned     lead;
    longint unsigned mant;
    longint unsigned frac;
    lead = 0;
    frac = 0;
    for (int i = 0; i < 32; i++)
      if (x[i]) lead = i;
    if (lead <= 30) mant = 64'(x) << (30 - lead);
    else mant = 64'(x) >> (lead - 30);
    for (int i = 0; i < RATIO_FRAC_BITS; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd2 << 30)) begin
        frac = frac | 1;
        mant = mant >> 1;
      end
    end
    return (64'(lead) << RATIO_FRAC_BITS) | frac;
  endfunction

  // Expected pixel for one hit count under the current configuration.
  function automatic pixel_t tone_map(logic [31:0] hits);
    pixel_t          px;
    longint unsigned ratio;
    px = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd255};
    if (hits <= 1 || norm_count <= 1) return px;
    ratio = (fixed_log2(hits) << RATIO_FRAC_BITS) / fixed_log2(norm_count);
    if (ratio > (64'd1 << RATIO_FRAC_BITS)) ratio = 64'd1 << RATIO_FRAC_BITS;
    if (ratio <= (64'd1 << (RATIO_FRAC_BITS - 2))) return px;
    if (scale_alpha) begin
      px.red   = base_red;
      px.green = base_green;
      px.blue  = base_blue;
      px.alpha = 8'((255 * ratio) >> RATIO_FRAC_BITS);
    end else begin
      px.red   = 8'((base_red * ratio) >> RATIO_FRAC_BITS);
      px.green = 8'((base_green * ratio) >> RATIO_FRAC_BITS);
      px.blue  = 8'((base_blue * ratio) >> RATIO_FRAC_BITS);
    end
    return px;
  endfunction

  // Driver: predicts each accepted beat and presents the next count after a random gap.
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.hit_count <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) pixel_q.push_back(tone_map(in_ch.hit_count));
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left    <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (count_q.size() > 0) begin
          in_ch.hit_count <= count_q.pop_front();
          in_ch.valid     <= 1'b1;
          gap_left <= (gaps_on && $urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each pixel beat against the oldest prediction, stalls at random.
  int stall_left = 0;
  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pixel_q.size() == 0) begin
          $error("pixel beat with no prediction waiting");
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (out_ch.pixel_red !== want.red) begin
            $error("pixel_red expected %0d got %0d", want.red, out_ch.pixel_red);
            errors++;
          end
          if (out_ch.pixel_green !== want.green) begin
            $error("pixel_green expected %0d got %0d", want.green, out_ch.pixel_green);
            errors++;
          end
          if (out_ch.pixel_blue !== want.blue) begin
            $error("pixel_blue expected %0d got %0d", want.blue, out_ch.pixel_blue);
            errors++;
          end
          if (out_ch.pixel_alpha !== want.alpha) begin
            $error("pixel_alpha expected %0d got %0d", want.alpha, out_ch.pixel_alpha);
            errors++;
          end
        end
        stall_left = (stalls_on && $urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
      end
      if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Register write over the configuration channel; the local copy follows the beat.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_MAX_COUNT:    norm_count  = value;
      REG_COLOUR_RED:   base_red    = value[7:0];
      REG_COLOUR_GREEN: base_green  = value[7:0];
      REG_COLOUR_BLUE:  base_blue   = value[7:0];
      REG_ALPHA_MODE:   scale_alpha = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] mx, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic am);
    write_reg(REG_MAX_COUNT, mx);
    write_reg(REG_COLOUR_RED, ({$urandom} & 32'hFFFF_FF00) | 32'(r));
    write_reg(REG_COLOUR_GREEN, 32'(g));
    write_reg(REG_COLOUR_BLUE, 32'(b));
    write_reg(REG_ALPHA_MODE, {31'($urandom), am});
  endtask

  // Pause until every queued count is sent and every pixel is back, then let the
  // pipeline drain.
  task automatic drain();
    do @(negedge clk); while (count_q.size() != 0 || in_ch.valid || pixel_q.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  // Counts spread over all magnitudes, with neighbors of the normalizer mixed in.
  function automatic logic [31:0] draw_count();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return norm_count + 32'($urandom_range(0, 4)) - 32'd2;
      2:       return 32'($urandom_range(0, 3));
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    logic [31:0] mx;
    in_ch.valid     = 1'b0;
    in_ch.hit_count = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: the normalizer of one gives black everywhere.
    count_q.push_back(32'd0);
    count_q.push_back(32'd1000);
    count_q.push_back(32'hFFFF_FFFF);
    drain();

    // Directed counts in colour mode with a moderate normalizer.
    set_config(32'd1000, 8'd255, 8'd128, 8'd0, 1'b0);
    foreach (colour_counts[i]) count_q.push_back(colour_counts[i]);
    drain();

    // Alpha mode, unknown register indexes that must be ignored, widest normalizer.
    set_config(32'hFFFF_FFFF, 8'd17, 8'd255, 8'd200, 1'b1);
    write_reg(3'd5, 32'd2);
    write_reg(3'd6, 32'd0);
    write_reg(3'd7, 32'hFFFF_FFFF);
    foreach (alpha_counts[i]) count_q.push_back(alpha_counts[i]);
    drain();

    // Random phases, each with its own configuration and idling pattern.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       mx = 32'd0;
        1:       mx = 32'd2;
        2:       mx = 32'd3;
        3:       mx = 32'hFFFF_FFFF;
        4:       mx = 32'h8000_0000;
        default: mx = $urandom >> $urandom_range(0, 30);
      endcase
      set_config(mx, (ph == 5) ? 8'd0 : 8'($urandom), (ph == 6) ? 8'd255 : 8'($urandom),
                 8'($urandom), ph[0]);
      gaps_on   = (ph % 4) != 2;
      stalls_on = (ph % 4) != 3;
      for (int n = 0; n < 150; n++) count_q.push_back(draw_count());
      drain();
    end

    if (errors == 0) begin
      $display("log_count_pixel_colour_map_core: match");
    end else begin
      $display("log_count_pixel_colour_map_core: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("log_count_pixel_colour_map_core: mismatch");
    $finish;
  end

endmodule
